/* design/assert_macros.svh */
// Assertion macros used by the checker file dsph_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, and not while reset is held.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_PROP(label, !(expr), msg)

`endif

/* design/dsph_pkg.sv */
`timescale 1ns / 1ps
package dsph_pkg;

    typedef enum logic [1:0] {
        OP_FRAME   = 2'd0,
        OP_SERVICE = 2'd1,
        OP_LIST    = 2'd2,
        OP_BACKEND = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OUT_STEERED    = 3'd0,
        OUT_MALFORMED  = 3'd1,
        OUT_NOT_L4     = 3'd2,
        OUT_NO_SERVICE = 3'd3,
        OUT_RANGE      = 3'd4,
        OUT_NO_BACKEND = 3'd5,
        OUT_WRITE_DONE = 3'd6
    } outcome_t;

    localparam logic [0:0] CFG_LOCAL_MAC       = 1'b0;
    localparam logic [0:0] CFG_LOCAL_MAC_VALID = 1'b1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [16:0] ETH_LEN     = 17'd14;
    localparam logic [16:0] IP_LEN      = 17'd20;
    localparam logic [16:0] TCP_LEN     = 17'd20;
    localparam logic [16:0] UDP_LEN     = 17'd8;
    localparam logic [16:0] IHL_UNIT    = 17'd4;
    localparam logic [7:0]  COUNT_MAX   = 8'd255;

    typedef struct packed {
        op_t         op;
        logic        done;
        outcome_t    code;
        logic [5:0]  slot;
        logic [7:0]  count;
        logic [31:0] src;
        logic [5:0]  tidx;
        logic [3:0]  pos;
        logic [47:0] wval;
        logic        ev;
    } item_t;

endpackage

/* design/dsr_source_hash_packet_steering.sv */
`timescale 1ns / 1ps
// Source-hash steering for a direct-server-return load balancer.
// A beat is taken at each rising edge where start is high and busy is low.
// Opcode 0 carries one frame's header fields; opcodes 1 to 3 write the
// service table, a backend list slot or a backend MAC.
// Every beat, frame or write, gives exactly one result, shown for one cycle
// with result_valid high once it has left the output register.
// Beats may follow in every cycle: busy never rises, and the pipeline holds
// up to eight beats at once, one per stage. Each beat passes in order through
// the service lookup, the four stages of the source-address remainder unit,
// the backend list read, the backend MAC read and the output register.
// The receiver cannot stall, so results leave the output register in order.
// The local MAC registers are written through the cfg channel, whose ready
// is always high; write them only while no beat is in flight.
// Reset empties the pipeline and clears the service, list and backend
// valid bits; it takes effect at once, with no clearing pass.
module dsr_source_hash_packet_steering
    import dsph_pkg::*;
#(
    parameter int NUM_SERVICES         = 16,
    parameter int BACKENDS_PER_SERVICE = 16,
    parameter int POOL_SIZE            = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [15:0] dst_port,
    input  logic [5:0]  table_index,
    input  logic [3:0]  list_position,
    input  logic [47:0] write_value,
    input  logic        entry_valid,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output logic        result_valid,
    output logic        transmit,
    output logic [2:0]  outcome,
    output logic [47:0] new_dst_mac,
    output logic        src_mac_replace,
    output logic [47:0] new_src_mac,
    output logic [5:0]  chosen_backend
);

    logic [47:0] local_mac_reg;
    logic        local_mac_valid_reg;
    logic        cls_valid;
    item_t       cls_item;
    logic        div_valid;
    item_t       div_item;
    logic [7:0]  div_rem;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg       <= '0;
            local_mac_valid_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LOCAL_MAC:       local_mac_reg       <= cfg_data;
                CFG_LOCAL_MAC_VALID: local_mac_valid_reg <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    dsph_classify #(
        .NUM_SERVICES(NUM_SERVICES)
    ) u_classify (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && !busy),
        .opcode         (opcode),
        .frame_length   (frame_length),
        .ether_type     (ether_type),
        .ip_header_words(ip_header_words),
        .ip_protocol    (ip_protocol),
        .src_address    (src_address),
        .dst_address    (dst_address),
        .dst_port       (dst_port),
        .table_index    (table_index),
        .list_position  (list_position),
        .write_value    (write_value),
        .entry_valid    (entry_valid),
        .out_valid      (cls_valid),
        .out_item       (cls_item)
    );

    dsph_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cls_valid),
        .in_item  (cls_item),
        .out_valid(div_valid),
        .out_item (div_item),
        .out_rem  (div_rem)
    );

    dsph_backend #(
        .NUM_SERVICES        (NUM_SERVICES),
        .BACKENDS_PER_SERVICE(BACKENDS_PER_SERVICE),
        .POOL_SIZE           (POOL_SIZE)
    ) u_backend (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (div_valid),
        .in_item        (div_item),
        .in_rem         (div_rem),
        .local_mac      (local_mac_reg),
        .local_mac_valid(local_mac_valid_reg),
        .result_valid   (result_valid),
        .transmit       (transmit),
        .outcome        (outcome),
        .new_dst_mac    (new_dst_mac),
        .src_mac_replace(src_mac_replace),
        .new_src_mac    (new_src_mac),
        .chosen_backend (chosen_backend)
    );

endmodule

/* design/dsph_classify.sv */
`timescale 1ns / 1ps
module dsph_classify
    import dsph_pkg::*;
#(
    parameter int NUM_SERVICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  opcode,
    input  logic [15:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [3:0]  ip_header_words,
    input  logic [7:0]  ip_protocol,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [15:0] dst_port,
    input  logic [5:0]  table_index,
    input  logic [3:0]  list_position,
    input  logic [47:0] write_value,
    input  logic        entry_valid,
    output logic        out_valid,
    output item_t       out_item
);

    localparam int SLOT_W = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;

    logic [31:0] svc_addr_reg  [NUM_SERVICES];
    logic [15:0] svc_port_reg  [NUM_SERVICES];
    logic [7:0]  svc_count_reg [NUM_SERVICES];
    logic [NUM_SERVICES-1:0] svc_valid_reg;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic        hit;
    logic [5:0]  slot;
    logic [16:0] len;
    logic [16:0] l4_len;
    logic [16:0] hdr_len;
    logic        svc_wr;

    assign len     = {1'b0, frame_length};
    assign l4_len  = (ip_protocol == PROTO_TCP) ? TCP_LEN : UDP_LEN;
    assign hdr_len = ETH_LEN + 17'(ip_header_words) * IHL_UNIT + l4_len;
    assign svc_wr  = in_valid && (op_t'(opcode) == OP_SERVICE)
                     && (32'(table_index) < NUM_SERVICES);

    always_comb
    begin
        hit  = 1'b0;
        slot = '0;
        for (int i = NUM_SERVICES - 1; i >= 0; i--)
        begin
            if (svc_valid_reg[i] && svc_addr_reg[i] == dst_address
                && svc_port_reg[i] == dst_port)
            begin
                hit  = 1'b1;
                slot = 6'(i);
            end
        end
    end

    always_comb
    begin
        item_next       = '0;
        item_next.op    = op_t'(opcode);
        item_next.src   = src_address;
        item_next.tidx  = table_index;
        item_next.pos   = list_position;
        item_next.wval  = write_value;
        item_next.ev    = entry_valid;
        item_next.slot  = slot;
        item_next.count = svc_count_reg[slot[SLOT_W-1:0]];
        item_next.code  = OUT_STEERED;
        if (op_t'(opcode) != OP_FRAME)
        begin
            item_next.done = 1'b1;
            item_next.code = OUT_WRITE_DONE;
        end
        else if (len < ETH_LEN || ether_type != ETHERTYPE_IPV4 || len < ETH_LEN + IP_LEN)
        begin
            item_next.done = 1'b1;
            item_next.code = OUT_MALFORMED;
        end
        else if (ip_protocol != PROTO_TCP && ip_protocol != PROTO_UDP)
        begin
            item_next.done = 1'b1;
            item_next.code = OUT_NOT_L4;
        end
        else if (hdr_len > len)
        begin
            item_next.done = 1'b1;
            item_next.code = OUT_MALFORMED;
        end
        else if (!hit || item_next.count == 8'd0)
        begin
            item_next.done = 1'b1;
            item_next.code = OUT_NO_SERVICE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            svc_valid_reg <= '0;
        end
        else
        begin
            valid_reg <= in_valid;
            if (svc_wr)
            begin
                svc_valid_reg[table_index[SLOT_W-1:0]] <= entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        if (svc_wr)
        begin
            svc_addr_reg[table_index[SLOT_W-1:0]]  <= dst_address;
            svc_port_reg[table_index[SLOT_W-1:0]]  <= dst_port;
            svc_count_reg[table_index[SLOT_W-1:0]] <=
                (write_value > 48'(COUNT_MAX)) ? COUNT_MAX : write_value[7:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* design/dsph_divider.sv */
`timescale 1ns / 1ps
module dsph_divider
    import dsph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  item_t      in_item,
    output logic       out_valid,
    output item_t      out_item,
    output logic [7:0] out_rem
);

    localparam int STAGES = 4;
    localparam int BITS   = 32 / STAGES;

    logic       valid_reg [STAGES];
    item_t      item_reg  [STAGES];
    logic [7:0] rem_reg   [STAGES];
    logic [7:0] rem_next  [STAGES];
    logic       prev_valid [STAGES];
    item_t      prev_item  [STAGES];
    logic [7:0] prev_rem   [STAGES];

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_link
            if (g == 0)
            begin : g_first
                assign prev_valid[g] = in_valid;
                assign prev_item[g]  = in_item;
                assign prev_rem[g]   = 8'd0;
            end
            else
            begin : g_rest
                assign prev_valid[g] = valid_reg[g-1];
                assign prev_item[g]  = item_reg[g-1];
                assign prev_rem[g]   = rem_reg[g-1];
            end
        end
    endgenerate

    always_comb
    begin
        logic [7:0] r;
        logic [8:0] t;
        for (int s = 0; s < STAGES; s++)
        begin
            r = prev_rem[s];
            for (int b = 0; b < BITS; b++)
            begin
                t = {r, prev_item[s].src[31 - s * BITS - b]};
                if (t >= {1'b0, prev_item[s].count})
                begin
                    r = 8'(t - {1'b0, prev_item[s].count});
                end
                else
                begin
                    r = t[7:0];
                end
            end
            rem_next[s] = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                valid_reg[s] <= prev_valid[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < STAGES; s++)
        begin
            item_reg[s] <= prev_item[s];
            rem_reg[s]  <= rem_next[s];
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign out_rem   = rem_reg[STAGES-1];

endmodule

/* design/dsph_backend.sv */
`timescale 1ns / 1ps
module dsph_backend
    import dsph_pkg::*;
#(
    parameter int NUM_SERVICES         = 16,
    parameter int BACKENDS_PER_SERVICE = 16,
    parameter int POOL_SIZE            = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  item_t       in_item,
    input  logic [7:0]  in_rem,
    input  logic [47:0] local_mac,
    input  logic        local_mac_valid,
    output logic        result_valid,
    output logic        transmit,
    output logic [2:0]  outcome,
    output logic [47:0] new_dst_mac,
    output logic        src_mac_replace,
    output logic [47:0] new_src_mac,
    output logic [5:0]  chosen_backend
);

    localparam int LIST_DEPTH = NUM_SERVICES * BACKENDS_PER_SERVICE;
    localparam int LIST_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int POOL_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    logic [5:0]  list_mem [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] list_valid_reg;
    logic [47:0] mac_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] present_reg;

    item_t       a_item_next;
    logic [LIST_W-1:0] list_rd_addr;
    logic [LIST_W-1:0] list_wr_addr;
    logic        list_wr;
    logic        a_valid_reg;
    item_t       a_item_reg;
    logic [5:0]  a_list_reg;
    logic        a_lvalid_reg;

    logic [5:0]  pool;
    logic        pool_ok;
    item_t       b_item_next;
    logic        mac_wr;
    logic        b_valid_reg;
    item_t       b_item_reg;
    logic [5:0]  b_pool_reg;
    logic [47:0] b_mac_reg;

    logic        res_valid_reg;
    logic        transmit_reg;
    logic [2:0]  outcome_reg;
    logic [47:0] dst_mac_reg;
    logic        replace_reg;
    logic [47:0] src_mac_reg;
    logic [5:0]  chosen_reg;

    always_comb
    begin
        a_item_next = in_item;
        if (!in_item.done && 32'(in_rem) >= BACKENDS_PER_SERVICE)
        begin
            a_item_next.done = 1'b1;
            a_item_next.code = OUT_RANGE;
        end
    end

    assign list_rd_addr = LIST_W'(32'(in_item.slot) * BACKENDS_PER_SERVICE + 32'(in_rem));
    assign list_wr_addr = LIST_W'(32'(in_item.tidx) * BACKENDS_PER_SERVICE
                                  + 32'(in_item.pos));
    assign list_wr = in_valid && (in_item.op == OP_LIST)
                     && (32'(in_item.tidx) < NUM_SERVICES)
                     && (32'(in_item.pos) < BACKENDS_PER_SERVICE)
                     && (in_item.wval < 48'(POOL_SIZE));

    always_ff @(posedge clk)
    begin
        if (list_wr)
        begin
            list_mem[list_wr_addr] <= in_item.wval[5:0];
        end
        a_list_reg   <= list_mem[list_rd_addr];
        a_lvalid_reg <= list_valid_reg[list_rd_addr];
        a_item_reg   <= a_item_next;
    end

    assign pool    = a_lvalid_reg ? a_list_reg : 6'd0;
    assign pool_ok = (32'(pool) < POOL_SIZE) && present_reg[pool[POOL_W-1:0]];
    assign mac_wr  = a_valid_reg && (a_item_reg.op == OP_BACKEND)
                     && (32'(a_item_reg.tidx) < POOL_SIZE);

    always_comb
    begin
        b_item_next = a_item_reg;
        if (!a_item_reg.done && !pool_ok)
        begin
            b_item_next.done = 1'b1;
            b_item_next.code = OUT_NO_BACKEND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_wr && a_item_reg.ev)
        begin
            mac_mem[a_item_reg.tidx[POOL_W-1:0]] <= a_item_reg.wval;
        end
        b_mac_reg  <= mac_mem[pool[POOL_W-1:0]];
        b_pool_reg <= pool;
        b_item_reg <= b_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
            list_valid_reg <= '0;
            present_reg    <= '0;
        end
        else
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            res_valid_reg <= b_valid_reg;
            if (list_wr)
            begin
                list_valid_reg[list_wr_addr] <= 1'b1;
            end
            if (mac_wr)
            begin
                present_reg[a_item_reg.tidx[POOL_W-1:0]] <= a_item_reg.ev;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_item_reg.done)
        begin
            transmit_reg <= 1'b0;
            outcome_reg  <= b_item_reg.code;
            dst_mac_reg  <= '0;
            replace_reg  <= 1'b0;
            src_mac_reg  <= '0;
            chosen_reg   <= (b_item_reg.code == OUT_NO_BACKEND) ? b_pool_reg : 6'd0;
        end
        else
        begin
            transmit_reg <= 1'b1;
            outcome_reg  <= OUT_STEERED;
            dst_mac_reg  <= b_mac_reg;
            replace_reg  <= local_mac_valid;
            src_mac_reg  <= local_mac_valid ? local_mac : 48'd0;
            chosen_reg   <= b_pool_reg;
        end
    end

    assign result_valid    = res_valid_reg;
    assign transmit        = transmit_reg;
    assign outcome         = outcome_reg;
    assign new_dst_mac     = dst_mac_reg;
    assign src_mac_replace = replace_reg;
    assign new_src_mac     = src_mac_reg;
    assign chosen_backend  = chosen_reg;

endmodule

/* design/dsph_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dsph_checker
    import dsph_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input logic       transmit,
    input logic [2:0] outcome,
    input logic       src_mac_replace
);

    `ASSERT_PROP(a_fixed_latency, start && !busy |-> ##8 result_valid, "beat without result")
    `ASSERT_PROP(a_no_spurious, result_valid |-> $past(start && !busy, 8), "result without beat")
    `ASSERT_PROP(a_tx_steered, result_valid && transmit |-> outcome == OUT_STEERED, "bad tx code")
    `ASSERT_NEVER(a_replace_no_tx, result_valid && src_mac_replace && !transmit, "replace w/o tx")

endmodule

bind dsr_source_hash_packet_steering dsph_checker u_dsph_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import dsph_pkg::*;

    localparam int NSVC = 16;
    localparam int NPER = 16;
    localparam int NPOOL = 64;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic        tx;
        logic [2:0]  oc;
        logic [47:0] dmac;
        logic        rep;
        logic [47:0] smac;
        logic [5:0]  be;
    } steer_res_t;

    class steer_board;
        logic [47:0] lmac;
        logic        lmac_ok;
        logic [31:0] s_addr[NSVC];
        logic [15:0] s_port[NSVC];
        logic        s_ok[NSVC];
        logic [7:0]  s_cnt[NSVC];
        logic [5:0]  blist[NSVC*NPER];
        logic [47:0] bmac[NPOOL];
        logic        bok[NPOOL];
        steer_res_t  pending[$];
        int          errors;

        function new();
            lmac = 0;
            lmac_ok = 0;
            errors = 0;
            for (int i = 0; i < NSVC; i++)
            begin
                s_addr[i] = 0;
                s_port[i] = 0;
                s_ok[i] = 0;
                s_cnt[i] = 0;
            end
            for (int i = 0; i < NSVC*NPER; i++)
                blist[i] = 0;
            for (int i = 0; i < NPOOL; i++)
            begin
                bmac[i] = 0;
                bok[i] = 0;
            end
        endfunction

        function steer_res_t classify(logic [15:0] len, logic [15:0] et, logic [3:0] ihl,
                                      logic [7:0] pr, logic [31:0] src, logic [31:0] dst,
                                      logic [15:0] port);
            steer_res_t r;
            int l4;
            int slot;
            int idx;
            logic [5:0] pl;
            r = '0;
            slot = -1;
            if (len < 34 || et != ETHERTYPE_IPV4)
            begin
                r.oc = OUT_MALFORMED;
                return r;
            end
            if (pr == PROTO_TCP)
                l4 = 20;
            else if (pr == PROTO_UDP)
                l4 = 8;
            else
            begin
                r.oc = OUT_NOT_L4;
                return r;
            end
            if (14 + int'(ihl) * 4 + l4 > int'(len))
            begin
                r.oc = OUT_MALFORMED;
                return r;
            end
            for (int i = NSVC - 1; i >= 0; i--)
                if (s_ok[i] && s_addr[i] == dst && s_port[i] == port)
                    slot = i;
            if (slot < 0 || s_cnt[slot] == 0)
            begin
                r.oc = OUT_NO_SERVICE;
                return r;
            end
            idx = src % {24'd0, s_cnt[slot]};
            if (idx >= NPER)
            begin
                r.oc = OUT_RANGE;
                return r;
            end
            pl = blist[slot*NPER+idx];
            r.be = pl;
            if (!bok[pl])
            begin
                r.oc = OUT_NO_BACKEND;
                return r;
            end
            r.tx = 1;
            r.oc = OUT_STEERED;
            r.dmac = bmac[pl];
            r.rep = lmac_ok;
            r.smac = lmac_ok ? lmac : 48'd0;
            return r;
        endfunction

        function void note_beat(logic [1:0] op, logic [15:0] len, logic [15:0] et,
                                logic [3:0] ihl, logic [7:0] pr, logic [31:0] src,
                                logic [31:0] dst, logic [15:0] port, logic [5:0] ti,
                                logic [3:0] pos, logic [47:0] val, logic ev);
            steer_res_t r;
            r = '0;
            r.oc = OUT_WRITE_DONE;
            case (op)
                OP_FRAME: r = classify(len, et, ihl, pr, src, dst, port);
                OP_SERVICE:
                    if (ti < NSVC)
                    begin
                        s_addr[ti] = dst;
                        s_port[ti] = port;
                        s_ok[ti] = ev;
                        s_cnt[ti] = (val > 255) ? 8'd255 : val[7:0];
                    end
                OP_LIST:
                    if (ti < NSVC && val < NPOOL)
                        blist[ti*NPER+pos] = val[5:0];
                default:
                    if (ti < NPOOL)
                    begin
                        if (ev)
                            bmac[ti] = val;
                        bok[ti] = ev;
                    end
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(steer_res_t got);
            steer_res_t exp_r;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected tx=%b oc=%0d dmac=%h rep=%b smac=%h ",
                              "be=%0d, got tx=%b oc=%0d dmac=%h rep=%b smac=%h be=%0d"},
                             exp_r.tx, exp_r.oc, exp_r.dmac, exp_r.rep, exp_r.smac,
                             exp_r.be, got.tx, got.oc, got.dmac, got.rep, got.smac,
                             got.be);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] opcode = 0;
    logic [15:0] frame_length = 0;
    logic [15:0] ether_type = 0;
    logic [3:0] ip_header_words = 0;
    logic [7:0] ip_protocol = 0;
    logic [31:0] src_address = 0;
    logic [31:0] dst_address = 0;
    logic [15:0] dst_port = 0;
    logic [5:0] table_index = 0;
    logic [3:0] list_position = 0;
    logic [47:0] write_value = 0;
    logic entry_valid = 0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [0:0] cfg_index = 0;
    logic [47:0] cfg_data = 0;
    logic result_valid;
    logic transmit;
    logic [2:0] outcome;
    logic [47:0] new_dst_mac;
    logic src_mac_replace;
    logic [47:0] new_src_mac;
    logic [5:0] chosen_backend;

    steer_board board = new();
    int cycles = 0;
    logic [31:0] svc_addr[4];
    logic [15:0] svc_port[4];

    always #1 clk = ~clk;

    dsr_source_hash_packet_steering dut (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (rst_n && result_valid)
            board.check_result({transmit, outcome, new_dst_mac, src_mac_replace,
                                new_src_mac, chosen_backend});
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_beat(logic [1:0] op, logic [15:0] len, logic [15:0] et,
                             logic [3:0] ihl, logic [7:0] pr, logic [31:0] src,
                             logic [31:0] dst, logic [15:0] port, logic [5:0] ti,
                             logic [3:0] pos, logic [47:0] val, logic ev);
        start <= 1;
        opcode <= op;
        frame_length <= len;
        ether_type <= et;
        ip_header_words <= ihl;
        ip_protocol <= pr;
        src_address <= src;
        dst_address <= dst;
        dst_port <= port;
        table_index <= ti;
        list_position <= pos;
        write_value <= val;
        entry_valid <= ev;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_beat(op, len, et, ihl, pr, src, dst, port, ti, pos, val, ev);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            start <= 0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [47:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_LOCAL_MAC)
            board.lmac = data;
        else
            board.lmac_ok = data[0];
        @(negedge clk);
        cfg_valid <= 0;
        @(negedge clk);
    endtask

    task automatic rand_frame(int s);
        logic [7:0] pr;
        logic [15:0] len;
        logic [15:0] et;
        logic [31:0] dst;
        logic [15:0] port;
        pr = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
        len = 16'($urandom_range(40, 1600));
        et = ETHERTYPE_IPV4;
        dst = svc_addr[s];
        port = svc_port[s];
        case ($urandom_range(0, 9))
            0: pr = 8'($urandom);
            1: et = 16'($urandom);
            2: len = 16'($urandom);
            3: len = 16'($urandom_range(0, 60));
            4: dst = $urandom;
            5: port = 16'($urandom);
            default: ;
        endcase
        send_beat(OP_FRAME, len, et, $urandom_range(0, 1) ? 4'd5 : 4'($urandom), pr,
                  $urandom, dst, port, 6'($urandom), 4'($urandom),
                  48'({$urandom, $urandom}), 1'($urandom));
    endtask

    task automatic rand_write();
        int k;
        logic [47:0] val;
        k = $urandom_range(0, 3);
        case ($urandom_range(1, 3))
            OP_SERVICE:
            begin
                val = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom})
                                                   : 48'($urandom_range(0, 20));
                send_beat(OP_SERVICE, 16'($urandom), 16'($urandom), 4'($urandom),
                          8'($urandom), $urandom, svc_addr[k], svc_port[k],
                          ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'(k),
                          4'($urandom), val, $urandom_range(0, 5) != 0);
            end
            OP_LIST:
            begin
                val = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom})
                                                   : 48'($urandom_range(0, 63));
                send_beat(OP_LIST, 16'($urandom), 16'($urandom), 4'($urandom),
                          8'($urandom), $urandom, $urandom, 16'($urandom),
                          ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'(k),
                          4'($urandom), val, 1'($urandom));
            end
            default:
                send_beat(OP_BACKEND, 16'($urandom), 16'($urandom), 4'($urandom),
                          8'($urandom), $urandom, $urandom, 16'($urandom),
                          6'($urandom), 4'($urandom), 48'({$urandom, $urandom}),
                          $urandom_range(0, 4) != 0);
        endcase
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
        begin
            svc_addr[i] = $urandom;
            svc_port[i] = 16'($urandom);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        write_reg(CFG_LOCAL_MAC, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_LOCAL_MAC_VALID, 48'd1);
        send_beat(OP_FRAME, 16'd0, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 0, 0, 0, 0, 0, 0, 0);
        send_beat(OP_FRAME, 16'hFFFF, 16'hFFFF, 4'd5, PROTO_TCP, 0, 0, 0, 0, 0, 0, 0);
        send_beat(OP_FRAME, 16'hFFFF, ETHERTYPE_IPV4, 4'd15, 8'hFF, 0, 0, 0, 0, 0, 0, 0);
        send_beat(OP_FRAME, 16'd100, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 32'hFFFFFFFF,
                  svc_addr[0], svc_port[0], 0, 0, 0, 0);
        send_beat(OP_SERVICE, 0, 0, 0, 0, 0, svc_addr[0], svc_port[0], 0, 0, 48'd0, 1);
        send_beat(OP_FRAME, 16'd54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 7, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_SERVICE, 0, 0, 0, 0, 0, svc_addr[0], svc_port[0], 6'd1, 0,
                  48'hFFFF_FFFF_FFFF, 1);
        send_beat(OP_SERVICE, 0, 0, 0, 0, 0, svc_addr[0], svc_port[0], 6'd63, 0, 48'd3, 1);
        send_beat(OP_FRAME, 16'd54, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 7, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_FRAME, 16'd53, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 7, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_FRAME, 16'd42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 32'd254, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_LIST, 0, 0, 0, 0, 0, 0, 0, 6'd1, 4'd15, 48'd63, 0);
        send_beat(OP_LIST, 0, 0, 0, 0, 0, 0, 0, 6'd1, 4'd14, 48'd64, 0);
        send_beat(OP_LIST, 0, 0, 0, 0, 0, 0, 0, 6'd40, 4'd0, 48'd5, 0);
        send_beat(OP_FRAME, 16'd54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd15, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_BACKEND, 0, 0, 0, 0, 0, 0, 0, 6'd63, 0, 48'hFFFF_FFFF_FFFF, 1);
        send_beat(OP_FRAME, 16'd54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd15, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_BACKEND, 0, 0, 0, 0, 0, 0, 0, 6'd63, 0, 48'd0, 0);
        send_beat(OP_FRAME, 16'd54, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 32'd15, svc_addr[0],
                  svc_port[0], 0, 0, 0, 0);
        send_beat(OP_SERVICE, 0, 0, 0, 0, 0, svc_addr[0], svc_port[0], 6'd0, 0, 48'd0, 0);
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(CFG_LOCAL_MAC, (phase == 1) ? 48'd0 : 48'({$urandom, $urandom}));
            write_reg(CFG_LOCAL_MAC_VALID, {47'd0, phase[0]});
            for (int i = 0; i < 30; i++)
                send_beat(OP_BACKEND, 0, 0, 0, 0, 0, 0, 0, 6'($urandom), 0,
                          48'({$urandom, $urandom}), 1);
            for (int n = 0; n < 70; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    rand_write();
                else
                    rand_frame($urandom_range(0, 3));
                if (phase != 2)
                    idle_gap();
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
